// ----- rtl/scheme_source_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// Scheme source tokenizer assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SCHEME_SOURCE_TOKENIZER_DEFINES_SVH
`define SCHEME_SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheme source tokenizer package
// Token kinds, scan modes, character codes and the result item type.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int POS_WIDTH_DEF = 32;
	localparam int OQ_DEPTH      = 4;
	localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W      = OQ_PTR_W + 1;

	typedef enum logic [3:0] {
		K_EOF     = 4'd0,
		K_IDENT   = 4'd1,
		K_INT     = 4'd2,
		K_STRING  = 4'd3,
		K_LPAREN  = 4'd4,
		K_RPAREN  = 4'd5,
		K_EQEQ    = 4'd6,
		K_EQ      = 4'd7,
		K_ARROW   = 4'd8,
		K_MINUS   = 4'd9,
		K_DOT     = 4'd10,
		K_PLUS    = 4'd11,
		K_STAR    = 4'd12,
		K_SLASH   = 4'd13,
		K_COMMENT = 4'd14,
		K_SYMBOL  = 4'd15
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_UNTERM  = 2'd1,
		ERR_BAD_AMP = 2'd2
	} err_t;

	typedef enum logic [10:0] {
		M_IDLE    = 11'b000_0000_0001,
		M_IDENT   = 11'b000_0000_0010,
		M_INT     = 11'b000_0000_0100,
		M_STR     = 11'b000_0000_1000,
		M_EQ      = 11'b000_0001_0000,
		M_MINUS   = 11'b000_0010_0000,
		M_STAR    = 11'b000_0100_0000,
		M_AMP     = 11'b000_1000_0000,
		M_PIDENT  = 11'b001_0000_0000,
		M_COMMENT = 11'b010_0000_0000,
		M_DEAD    = 11'b100_0000_0000
	} mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [31:0] start;
		logic [31:0] length;
		err_t        error;
		logic        last;
	} tok_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ----- rtl/sst_scan.sv -----
// ----------------------------------------------------------------------------
// Scheme source tokenizer scan step
// Combinational next mode, offsets and up to two result items for one byte.
// ----------------------------------------------------------------------------
module sst_scan #(
	parameter int POS_WIDTH = sst_pkg::POS_WIDTH_DEF
) (
	input  logic [7:0]           ch,
	input  sst_pkg::mode_t       mode,
	input  logic [POS_WIDTH-1:0] tok_begin,
	input  logic [POS_WIDTH-1:0] pos,
	output sst_pkg::mode_t       mode_n,
	output logic [POS_WIDTH-1:0] tok_begin_n,
	output logic [POS_WIDTH-1:0] pos_n,
	output logic [1:0]           n_res,
	output sst_pkg::tok_t        res0,
	output sst_pkg::tok_t        res1
);
	import sst_pkg::*;

	function automatic logic [31:0] to32(input logic [POS_WIDTH-1:0] x);
		logic [63:0] w;
		w = 64'(x);
		return w[31:0];
	endfunction

	logic                 space;
	logic                 idle_v;
	kind_t                idle_kind;
	mode_t                idle_mode;
	logic                 idle_end;
	logic                 pre_v;
	kind_t                pre_kind;
	logic [POS_WIDTH-1:0] pre_len;
	err_t                 pre_err;
	logic                 use_idle;
	mode_t                hold_mode;
	logic                 hold_end;
	logic                 ended;
	tok_t                 pre_tok;
	tok_t                 idle_tok;

	// Start of a new token from the idle mode
	always_comb begin
		space     = is_space(ch);
		idle_v    = 1'b0;
		idle_kind = K_SYMBOL;
		idle_mode = M_IDLE;
		idle_end  = 1'b0;
		if (!space) begin
			if (ch == CH_NUL) begin
				idle_v    = 1'b1;
				idle_kind = K_EOF;
				idle_end  = 1'b1;
			end else if (is_alpha(ch)) begin
				idle_mode = M_IDENT;
			end else if (is_digit(ch)) begin
				idle_mode = M_INT;
			end else begin
				case (ch)
					CH_QUOTE:  idle_mode = M_STR;
					CH_EQ:     idle_mode = M_EQ;
					CH_MINUS:  idle_mode = M_MINUS;
					CH_STAR:   idle_mode = M_STAR;
					CH_AMP:    idle_mode = M_AMP;
					CH_SEMI:   idle_mode = M_COMMENT;
					CH_LPAREN: begin idle_v = 1'b1; idle_kind = K_LPAREN; end
					CH_RPAREN: begin idle_v = 1'b1; idle_kind = K_RPAREN; end
					CH_DOT:    begin idle_v = 1'b1; idle_kind = K_DOT;    end
					CH_PLUS:   begin idle_v = 1'b1; idle_kind = K_PLUS;   end
					CH_SLASH:  begin idle_v = 1'b1; idle_kind = K_SLASH;  end
					default:   begin idle_v = 1'b1; idle_kind = K_SYMBOL; end
				endcase
			end
		end
	end

	// Close the pending token, or keep scanning it
	always_comb begin
		pre_v     = 1'b0;
		pre_kind  = K_SYMBOL;
		pre_len   = '0;
		pre_err   = ERR_NONE;
		use_idle  = 1'b0;
		hold_mode = mode;
		hold_end  = 1'b0;
		case (mode)
			M_IDENT: begin
				if (!(is_alpha(ch) || is_digit(ch) || ch == CH_UNDER || ch == CH_STAR
						|| ch == CH_AMP)) begin
					pre_v    = 1'b1;
					pre_kind = K_IDENT;
					pre_len  = pos - tok_begin;
					use_idle = 1'b1;
				end
			end
			M_INT: begin
				if (!is_digit(ch)) begin
					pre_v    = 1'b1;
					pre_kind = K_INT;
					pre_len  = pos - tok_begin;
					use_idle = 1'b1;
				end
			end
			M_PIDENT: begin
				if (!(is_alpha(ch) || is_digit(ch) || ch == CH_UNDER)) begin
					pre_v    = 1'b1;
					pre_kind = K_IDENT;
					pre_len  = pos - tok_begin;
					use_idle = 1'b1;
				end
			end
			M_STR: begin
				if (ch == CH_QUOTE) begin
					pre_v     = 1'b1;
					pre_kind  = K_STRING;
					pre_len   = pos + POS_WIDTH'(1) - tok_begin;
					hold_mode = M_IDLE;
				end else if (ch == CH_NUL) begin
					pre_v     = 1'b1;
					pre_kind  = K_STRING;
					pre_len   = pos - tok_begin;
					pre_err   = ERR_UNTERM;
					hold_mode = M_IDLE;
					hold_end  = 1'b1;
				end
			end
			M_EQ: begin
				pre_v = 1'b1;
				if (ch == CH_EQ) begin
					pre_kind  = K_EQEQ;
					pre_len   = POS_WIDTH'(2);
					hold_mode = M_IDLE;
				end else begin
					pre_kind = K_EQ;
					pre_len  = POS_WIDTH'(1);
					use_idle = 1'b1;
				end
			end
			M_MINUS: begin
				pre_v = 1'b1;
				if (ch == CH_GT) begin
					pre_kind  = K_ARROW;
					pre_len   = POS_WIDTH'(2);
					hold_mode = M_IDLE;
				end else begin
					pre_kind = K_MINUS;
					pre_len  = POS_WIDTH'(1);
					use_idle = 1'b1;
				end
			end
			M_STAR: begin
				if (is_alpha(ch)) begin
					hold_mode = M_PIDENT;
				end else begin
					pre_v    = 1'b1;
					pre_kind = K_STAR;
					pre_len  = POS_WIDTH'(1);
					use_idle = 1'b1;
				end
			end
			M_AMP: begin
				if (is_alpha(ch)) begin
					hold_mode = M_PIDENT;
				end else begin
					pre_v    = 1'b1;
					pre_kind = K_SYMBOL;
					pre_len  = POS_WIDTH'(1);
					pre_err  = ERR_BAD_AMP;
					if (ch == CH_NUL) begin
						hold_mode = M_IDLE;
						hold_end  = 1'b1;
					end else begin
						hold_mode = M_DEAD;
					end
				end
			end
			M_COMMENT: begin
				if (ch == CH_NL || ch == CH_NUL) begin
					pre_v    = 1'b1;
					pre_kind = K_COMMENT;
					use_idle = 1'b1;
				end
			end
			M_DEAD: begin
				if (ch == CH_NUL) begin
					hold_mode = M_IDLE;
					hold_end  = 1'b1;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase
	end

	// Merge both paths into the next state and the result pair
	always_comb begin
		mode_n      = use_idle ? idle_mode : hold_mode;
		ended       = use_idle ? idle_end : hold_end;
		tok_begin_n = (use_idle && !space) ? pos : tok_begin;
		pos_n       = ended ? '0 : pos + POS_WIDTH'(1);

		pre_tok.kind   = pre_kind;
		pre_tok.start  = to32(tok_begin);
		pre_tok.length = to32(pre_len);
		pre_tok.error  = pre_err;
		pre_tok.last   = 1'b1;

		idle_tok.kind   = idle_kind;
		idle_tok.start  = to32(pos);
		idle_tok.length = (idle_kind == K_EOF) ? 32'd0 : 32'd1;
		idle_tok.error  = ERR_NONE;
		idle_tok.last   = 1'b1;

		res0 = pre_v ? pre_tok : idle_tok;
		res1 = idle_tok;
		if (pre_v && use_idle && idle_v) begin
			n_res         = 2'd2;
			res0.last     = 1'b0;
		end else if (pre_v || (use_idle && idle_v)) begin
			n_res = 2'd1;
		end else begin
			n_res = 2'd0;
		end
	end

endmodule

// ----- rtl/sst_outq.sv -----
// ----------------------------------------------------------------------------
// Scheme source tokenizer result queue
// Small queue that takes up to two result items per cycle and gives one.
// ----------------------------------------------------------------------------
module sst_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_n,
	input  sst_pkg::tok_t          d0,
	input  sst_pkg::tok_t          d1,
	input  logic                   pop,
	output sst_pkg::tok_t          head,
	output logic [sst_pkg::OQ_CNT_W-1:0] count
);
	import sst_pkg::*;

	tok_t                mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_q;
	logic [OQ_PTR_W-1:0] rd_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic [OQ_PTR_W-1:0] wr_next;

	assign wr_next = wr_q + OQ_PTR_W'(1);
	assign head    = mem_q[rd_q];
	assign count   = count_q;

	// Store the new items
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_next] <= d1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OQ_PTR_W'(push_n);
			rd_q    <= rd_q + OQ_PTR_W'(pop);
			count_q <= count_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

endmodule

// ----- rtl/scheme_source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Scheme source tokenizer
// Splits a byte stream of source text into tokens with kind, start, length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one source byte per item in s_tdata; byte 0 ends a
//   text and the next byte starts a new one at offset 0.
//   Output channel m_*: one token per item. m_tuser carries the kind, m_tdata
//   the start offset, length and error code, m_tlast marks the last token
//   caused by one input byte (a byte causes zero, one or two tokens).
//   Path: a taken byte waits in the input register, is scanned from there,
//   and its tokens go through the result queue, whose head drives m_*.
//   Throughput: one byte per cycle while the receiver keeps up; a byte that
//   causes two tokens sends them one after the other, and the four-entry
//   result queue absorbs short bursts of those.
//   Stall: when the receiver holds m_tready low the queue fills, the scan
//   register holds its byte, and s_tready drops; nothing is lost.
//   Reset: the queue empties, the scan mode returns to idle between tokens
//   and both offsets return to zero.
// ----------------------------------------------------------------------------
`include "scheme_source_tokenizer_defines.svh"

module scheme_source_tokenizer #(
	parameter int POS_WIDTH = sst_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] tok_start, [63:32] tok_length,
	                               // [65:64] error, [71:66] zero
	output logic [3:0]  m_tuser,   // [3:0] kind
	output logic        m_tlast    // last
);
	import sst_pkg::*;

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	mode_t                mode_q;
	logic [POS_WIDTH-1:0] begin_q;
	logic [POS_WIDTH-1:0] pos_q;
	mode_t                mode_n;
	logic [POS_WIDTH-1:0] begin_n;
	logic [POS_WIDTH-1:0] pos_n;
	logic [1:0]           n_res;
	tok_t                 res0;
	tok_t                 res1;
	tok_t                 head;
	logic [OQ_CNT_W-1:0]  count;
	logic                 room;
	logic                 advance;
	logic                 pop;

	// Scan only when the queue can take two items
	assign room     = count <= OQ_CNT_W'(OQ_DEPTH - 2);
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;
	assign pop      = m_tvalid && m_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1 <= s_tdata;
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			pos_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
		end
	end

	sst_scan #(
		.POS_WIDTH(POS_WIDTH)
	) u_scan (
		.ch         (ch_s1),
		.mode       (mode_q),
		.tok_begin  (begin_q),
		.pos        (pos_q),
		.mode_n     (mode_n),
		.tok_begin_n(begin_n),
		.pos_n      (pos_n),
		.n_res      (n_res),
		.res0       (res0),
		.res1       (res1)
	);

	sst_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push_n(advance ? n_res : 2'd0),
		.d0    (res0),
		.d1    (res1),
		.pop   (pop),
		.head  (head),
		.count (count)
	);

	// Drive the result channel from the queue head
	assign m_tvalid = count != '0;
	assign m_tdata  = {6'd0, head.error, head.length, head.start};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

	`SST_ASSERT_NOW(a_queue_bound, 1'b1, count <= OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
	`SST_ASSERT_NEXT(a_hold_byte, valid_s1 && !room, valid_s1 && $stable(ch_s1),
		"stalled byte lost from the input register")
	`SST_ASSERT_NOW(a_eof_len, m_tvalid && m_tuser == K_EOF, m_tdata[63:32] == 32'd0,
		"end-of-text token with nonzero length")
	`SST_ASSERT_NEXT(a_ended_pos, advance && n_res != 2'd0 && res0.error == ERR_UNTERM,
		pos_q == '0, "text end did not rewind the offset")

endmodule

// ----- tb/sv/token_check.sv -----
// ----------------------------------------------------------------------------
// Token stream checker
// Watches the byte and token channels of the source tokenizer, scans every
// accepted byte with its own copy of the scan mode and offsets, queues the
// tokens that byte must produce and compares each accepted token against the
// oldest one waiting.
// ----------------------------------------------------------------------------
module token_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // [31:0] tok_start, [63:32] tok_length,
	                               // [65:64] error, [71:66] zero
	input  logic [3:0]  m_tuser,   // [3:0] kind
	input  logic        m_tlast,   // last
	output int          mismatch_count,
	output int          outstanding
);

	import sst_pkg::*;

	localparam int REPORT_LIMIT = 40;

	// Scanner copy
	mode_t       scan_mode;
	logic [31:0] token_begin;
	logic [31:0] byte_pos;
	bit          text_done;

	// Tokens owed by the block, oldest first, and those of the current byte
	tok_t expected_tokens[$];
	tok_t byte_tokens[$];
	tok_t seen_token;
	tok_t want_token;

	initial mismatch_count = 0;
	initial outstanding = 0;

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic bit is_numeral(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	task automatic add_token(input kind_t k, input logic [31:0] st, input logic [31:0] len,
			input err_t e);
		byte_tokens.push_back('{kind: k, start: st, length: len, error: e, last: 1'b0});
	endtask

	// Scan a byte that arrives between tokens
	task automatic start_token(input logic [7:0] c, input logic [31:0] p);
		scan_mode = M_IDLE;
		if (!is_blank(c)) begin
			token_begin = p;
			if (c == CH_NUL) begin
				text_done = 1'b1;
				add_token(K_EOF, p, 32'd0, ERR_NONE);
			end else if (is_letter(c)) begin
				scan_mode = M_IDENT;
			end else if (is_numeral(c)) begin
				scan_mode = M_INT;
			end else begin
				case (c)
					CH_QUOTE:  scan_mode = M_STR;
					CH_EQ:     scan_mode = M_EQ;
					CH_MINUS:  scan_mode = M_MINUS;
					CH_STAR:   scan_mode = M_STAR;
					CH_AMP:    scan_mode = M_AMP;
					CH_SEMI:   scan_mode = M_COMMENT;
					CH_LPAREN: add_token(K_LPAREN, p, 32'd1, ERR_NONE);
					CH_RPAREN: add_token(K_RPAREN, p, 32'd1, ERR_NONE);
					CH_DOT:    add_token(K_DOT, p, 32'd1, ERR_NONE);
					CH_PLUS:   add_token(K_PLUS, p, 32'd1, ERR_NONE);
					CH_SLASH:  add_token(K_SLASH, p, 32'd1, ERR_NONE);
					default:   add_token(K_SYMBOL, p, 32'd1, ERR_NONE);
				endcase
			end
		end
	endtask

	// Advance the scanner by one byte and queue the tokens it completes
	task automatic scan_byte(input logic [7:0] c);
		logic [31:0] p;
		tok_t        tail;
		p = byte_pos;
		text_done = 1'b0;
		case (scan_mode)
			M_IDENT: begin
				if (!(is_letter(c) || is_numeral(c) || c == CH_UNDER || c == CH_STAR ||
						c == CH_AMP)) begin
					add_token(K_IDENT, token_begin, p - token_begin, ERR_NONE);
					start_token(c, p);
				end
			end
			M_INT: begin
				if (!is_numeral(c)) begin
					add_token(K_INT, token_begin, p - token_begin, ERR_NONE);
					start_token(c, p);
				end
			end
			M_PIDENT: begin
				if (!(is_letter(c) || is_numeral(c) || c == CH_UNDER)) begin
					add_token(K_IDENT, token_begin, p - token_begin, ERR_NONE);
					start_token(c, p);
				end
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					add_token(K_STRING, token_begin, p + 32'd1 - token_begin, ERR_NONE);
					scan_mode = M_IDLE;
				end else if (c == CH_NUL) begin
					add_token(K_STRING, token_begin, p - token_begin, ERR_UNTERM);
					scan_mode = M_IDLE;
					text_done = 1'b1;
				end
			end
			M_EQ: begin
				if (c == CH_EQ) begin
					add_token(K_EQEQ, token_begin, 32'd2, ERR_NONE);
					scan_mode = M_IDLE;
				end else begin
					add_token(K_EQ, token_begin, 32'd1, ERR_NONE);
					start_token(c, p);
				end
			end
			M_MINUS: begin
				if (c == CH_GT) begin
					add_token(K_ARROW, token_begin, 32'd2, ERR_NONE);
					scan_mode = M_IDLE;
				end else begin
					add_token(K_MINUS, token_begin, 32'd1, ERR_NONE);
					start_token(c, p);
				end
			end
			M_STAR: begin
				if (is_letter(c)) begin
					scan_mode = M_PIDENT;
				end else begin
					add_token(K_STAR, token_begin, 32'd1, ERR_NONE);
					start_token(c, p);
				end
			end
			M_AMP: begin
				if (is_letter(c)) begin
					scan_mode = M_PIDENT;
				end else begin
					add_token(K_SYMBOL, token_begin, 32'd1, ERR_BAD_AMP);
					if (c == CH_NUL) begin
						scan_mode = M_IDLE;
						text_done = 1'b1;
					end else begin
						scan_mode = M_DEAD;
					end
				end
			end
			M_COMMENT: begin
				if (c == CH_NL || c == CH_NUL) begin
					add_token(K_COMMENT, token_begin, 32'd0, ERR_NONE);
					start_token(c, p);
				end
			end
			M_DEAD: begin
				// drop everything up to the end of the text
				if (c == CH_NUL) begin
					scan_mode = M_IDLE;
					text_done = 1'b1;
				end
			end
			default: start_token(c, p);
		endcase
		byte_pos = text_done ? 32'd0 : p + 32'd1;

		// Mark the final token of this byte, then queue them all
		if (byte_tokens.size() > 0) begin
			tail = byte_tokens.pop_back();
			tail.last = 1'b1;
			byte_tokens.push_back(tail);
		end
		while (byte_tokens.size() > 0)
			expected_tokens.push_back(byte_tokens.pop_front());
	endtask

	// Compare outgoing tokens, then scan the incoming byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode = M_IDLE;
			token_begin = '0;
			byte_pos = '0;
			expected_tokens.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_token = '{kind: kind_t'(m_tuser), start: m_tdata[31:0],
					length: m_tdata[63:32], error: err_t'(m_tdata[65:64]), last: m_tlast};
				if (expected_tokens.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: unexpected token kind %0d start %0d length %0d error %0d last %0b",
							$time, seen_token.kind, seen_token.start, seen_token.length,
							seen_token.error, seen_token.last);
					mismatch_count++;
				end else begin
					want_token = expected_tokens.pop_front();
					if (seen_token !== want_token) begin
						if (mismatch_count < REPORT_LIMIT) begin
							$display("%0t: expected kind %0d start %0d length %0d error %0d last %0b",
								$time, want_token.kind, want_token.start, want_token.length,
								want_token.error, want_token.last);
							$display("%0t:   actual kind %0d start %0d length %0d error %0d last %0b",
								$time, seen_token.kind, seen_token.start, seen_token.length,
								seen_token.error, seen_token.last);
						end
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				scan_byte(s_tdata);
			outstanding <= expected_tokens.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Feeds source text to the tokenizer byte by byte: a short hand-written text
// that touches every token kind and every error path, then random texts that
// are mostly well formed, with some broken endings and noise. The sender
// idles in bursts and the receiver stalls in changing patterns; the checker
// beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module testbench;

	import sst_pkg::*;

	localparam int RANDOM_BYTES = 1300;

	typedef enum {END_CLEAN, END_OPEN_STRING, END_BAD_AMP, END_NOISE} text_end_t;
	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_CHOKED} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	int mismatch_count;
	int outstanding;

	logic [7:0] source_text[$];

	scheme_source_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	token_check checker_inst (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #10 clk = ~clk;

	// Hold reset for the first cycles
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stop a hung run
	initial begin
		#(20 * 1000000);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic put_byte(input logic [7:0] b);
		source_text.push_back(b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_letter();
		int r;
		r = $urandom_range(0, 51);
		put_byte(8'(r < 26 ? 8'h61 + r : 8'h41 + r - 26));
	endtask

	// Letters, digits and '_', plus '*' and '&' where the run allows them
	task automatic put_word_tail(input int n, input bit with_marks);
		int r;
		repeat (n) begin
			r = $urandom_range(0, with_marks ? 65 : 63);
			if (r < 52)
				put_byte(8'(r < 26 ? 8'h61 + r : 8'h41 + r - 26));
			else if (r < 62)
				put_byte(8'(8'h30 + r - 52));
			else if (r < 64)
				put_byte(CH_UNDER);
			else
				put_byte(r == 64 ? CH_STAR : CH_AMP);
		end
	endtask

	task automatic put_blank();
		int r;
		repeat ($urandom_range(1, 3)) begin
			r = $urandom_range(0, 5);
			put_byte(8'(r == 5 ? 8'h20 : 8'h09 + r));
		end
	endtask

	// Any byte that neither closes a string nor ends the text
	task automatic put_string_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		put_byte(b == CH_QUOTE ? 8'h27 : b);
	endtask

	// Append the source text of one token of the given kind
	task automatic put_token(input kind_t k);
		string others;
		others = "!#$%',:<>?@[]^`{|}~";
		case (k)
			K_IDENT: begin
				if ($urandom_range(0, 2) == 0) begin
					put_byte($urandom_range(0, 1) ? CH_STAR : CH_AMP);
					put_letter();
					put_word_tail($urandom_range(0, 6), 1'b0);
				end else begin
					put_letter();
					put_word_tail($urandom_range(0, 7), 1'b1);
				end
			end
			K_INT: repeat ($urandom_range(1, 6)) put_byte(8'(8'h30 + $urandom_range(0, 9)));
			K_STRING: begin
				put_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6)) put_string_byte();
				put_byte(CH_QUOTE);
			end
			K_LPAREN: put_byte(CH_LPAREN);
			K_RPAREN: put_byte(CH_RPAREN);
			K_EQEQ: begin
				put_byte(CH_EQ);
				put_byte(CH_EQ);
			end
			K_EQ: put_byte(CH_EQ);
			K_ARROW: begin
				put_byte(CH_MINUS);
				put_byte(CH_GT);
			end
			K_MINUS: put_byte(CH_MINUS);
			K_DOT: put_byte(CH_DOT);
			K_PLUS: put_byte(CH_PLUS);
			K_STAR: put_byte(CH_STAR);
			K_SLASH: put_byte(CH_SLASH);
			K_COMMENT: begin
				put_byte(CH_SEMI);
				repeat ($urandom_range(0, 8)) put_string_byte();
				// leave some comments open so the text end cuts them off
				if ($urandom_range(0, 3) != 0)
					put_byte(CH_NL);
			end
			K_SYMBOL: begin
				if ($urandom_range(0, 1))
					put_byte(8'($urandom_range(128, 255)));
				else
					put_byte(others[$urandom_range(0, others.len() - 1)]);
			end
			default: put_byte(CH_NUL);
		endcase
	endtask

	// Build the source text, then send it in bursts
	initial begin : drive_source
		text_end_t  ending;
		logic [7:0] b;
		int         burst_left;

		// Every token kind, prefixed and lone star, comment to newline,
		// symbol 255, '=' cut by the text end, bad ampersand then dropped
		// bytes, bad ampersand on the end byte, unterminated string
		put_text("a_*&9(12)\"s\"==->-.+/**q\t;c\n&b");
		put_byte(8'hFF);
		put_byte(CH_EQ);
		put_byte(CH_NUL);
		put_text("&(z");
		put_byte(CH_NUL);
		put_byte(CH_AMP);
		put_byte(CH_NUL);
		put_text("\"u");
		put_byte(CH_NUL);

		// Random texts, mostly well formed
		while (source_text.size() < RANDOM_BYTES + 40) begin
			repeat ($urandom_range(1, 10)) begin
				put_token(kind_t'($urandom_range(1, 15)));
				if ($urandom_range(0, 2) != 0)
					put_blank();
			end
			ending = ($urandom_range(0, 3) == 0) ? text_end_t'($urandom_range(1, 3)) : END_CLEAN;
			case (ending)
				END_OPEN_STRING: begin
					put_byte(CH_QUOTE);
					repeat ($urandom_range(0, 4)) put_string_byte();
				end
				END_BAD_AMP: begin
					put_byte(CH_AMP);
					do
						b = 8'($urandom_range(0, 255));
					while ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A);
					put_byte(b);
					if (b == CH_NUL)
						continue;
					repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(1, 255)));
				end
				END_NOISE: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
				default: ;
			endcase
			put_byte(CH_NUL);
		end

		wait (arst_n);
		@(posedge clk);

		// Send with random gaps between bursts, some bursts long
		burst_left = $urandom_range(1, 30);
		for (int idx = 0; idx < source_text.size(); idx++) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 30);
			end
			s_tvalid <= 1'b1;
			s_tdata <= source_text[idx];
			burst_left--;
			do
				@(posedge clk);
			while (!s_tready);
		end
		s_tvalid <= 1'b0;

		// Drain every owed token, then give the block time to misbehave
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Accept tokens, switching stall pattern from phase to phase
	initial begin : drain_tokens
		rx_style_t style;
		int        phase_left;

		style = RX_FREE;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				style = rx_style_t'($urandom_range(0, 3));
				phase_left = $urandom_range(16, 128);
			end
			phase_left--;
			case (style)
				RX_FREE:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ($urandom_range(0, 19) == 0);
			endcase
		end
	end

endmodule
